// ===== rtl/fcm_pkg.sv =====
// Shared types, constants and helpers for the cluster chain manager.
package fcm_pkg;

    localparam int NUM_ENTRIES = 16384;
    localparam int IDX_W       = 14;
    localparam int LINK_W      = 15;
    localparam int CNT_W       = 15;
    localparam int WORD_W      = LINK_W + 1;

    localparam logic [LINK_W-1:0] NO_NEXT     = 15'h7FFF;
    localparam logic [CNT_W-1:0]  ENTRY_LIMIT = CNT_W'(NUM_ENTRIES);
    localparam logic [IDX_W-1:0]  LAST_ENTRY  = IDX_W'(NUM_ENTRIES - 1);

    typedef enum logic [1:0] {
        REQ_FORMAT = 2'd0,
        REQ_ALLOC  = 2'd1,
        REQ_SEEK   = 2'd2,
        REQ_FREE   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_END   = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SEEK_RD,
        S_SEEK_ISSUE,
        S_SCAN,
        S_LINK,
        S_FREE_RD,
        S_DONE
    } fsm_state_t;

    typedef enum logic {
        CTX_ALLOC,
        CTX_SEEK
    } scan_ctx_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [IDX_W-1:0] start_index;
        logic [IDX_W-1:0] link_count;
        logic             extend;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] entry_index;
        logic [CNT_W-1:0] freed_count;
    } out_item_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } seq_stat_t;

    function automatic out_item_t make_res(status_t st, logic [IDX_W-1:0] idx,
                                           logic [CNT_W-1:0] cnt);
        out_item_t r;
        r.status      = st;
        r.entry_index = idx;
        r.freed_count = cnt;
        return r;
    endfunction

endpackage

// ===== rtl/fat_cluster_chain_manager_core.sv =====
// Top level: input handshake, output register, sequencer and table RAM.
// Format sweeps every entry; allocate scans up from the lowest free entry; seek follows
// one link per table read, and with extend a step past the chain end claims a fresh entry
// by a scan; free releases entries along the chain and stops at an entry already free.
// Throughput: one item at a time; s_ready high only idle.
// Reset: a clearing sweep of all 16384 entries runs first, with s_ready low meanwhile.
module fat_cluster_chain_manager_core
    import fcm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    seq_stat_t         stat;
    out_item_t         res;
    logic              res_ready;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic              m_valid_reg;
    out_item_t         m_item_reg;

    assign s_ready   = stat.idle;
    assign res_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    fcm_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_item   (s_item),
        .stat      (stat),
        .res       (res),
        .res_ready (res_ready),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    fcm_table_ram #(
        .ADDR_W (IDX_W),
        .DATA_W (WORD_W)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Hold the result item until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stat.res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge aclk) begin
        if (stat.res_valid && res_ready) begin
            m_item_reg <= res;
        end
    end

endmodule

// ===== rtl/fcm_table_ram.sv =====
// Simple dual-port table RAM: one write port, one registered read port.
module fcm_table_ram #(
    parameter int ADDR_W = 14,
    parameter int DATA_W = 16
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Write the table word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read word
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/fcm_seq.sv =====
// Request sequencer: clears, scans and walks the table, one request at a time.
module fcm_seq
    import fcm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  in_item_t          in_item,
    output seq_stat_t         stat,
    output out_item_t         res,
    input  logic              res_ready,
    output logic              ram_we,
    output logic [IDX_W-1:0]  ram_waddr,
    output logic [WORD_W-1:0] ram_wdata,
    output logic              ram_re,
    output logic [IDX_W-1:0]  ram_raddr,
    input  logic [WORD_W-1:0] ram_rdata
);

    fsm_state_t       state_reg, state_next;
    in_item_t         req_reg, req_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             cur_used_reg, cur_used_next;
    logic [IDX_W-1:0] fresh_reg, fresh_next;
    scan_ctx_t        ctx_reg, ctx_next;
    logic [CNT_W-1:0] scan_addr_reg, scan_addr_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0] chk_addr_reg, chk_addr_next;
    logic [CNT_W-1:0] low_free_reg, low_free_next;
    logic [CNT_W-1:0] freed_reg, freed_next;
    logic             first_reg, first_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             fmt_reg, fmt_next;
    out_item_t        res_reg, res_next;

    logic [LINK_W-1:0] nx;
    logic              nx_ok;
    logic              rd_used;

    assign nx      = ram_rdata[LINK_W-1:0];
    assign rd_used = ram_rdata[LINK_W];
    assign nx_ok   = (nx != NO_NEXT) && (nx < ENTRY_LIMIT);
    assign res     = res_reg;

    // Hold control state; the reset starts a clearing sweep of the table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            fmt_reg       <= 1'b0;
            low_free_reg  <= CNT_W'(1);
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            fmt_reg       <= fmt_next;
            low_free_reg  <= low_free_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    // Hold working registers
    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        cur_reg       <= cur_next;
        k_reg         <= k_next;
        cur_used_reg  <= cur_used_next;
        fresh_reg     <= fresh_next;
        ctx_reg       <= ctx_next;
        scan_addr_reg <= scan_addr_next;
        chk_addr_reg  <= chk_addr_next;
        freed_reg     <= freed_next;
        first_reg     <= first_next;
        res_reg       <= res_next;
    end

    // Advance the sequencer and drive the table ports
    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        cur_used_next  = cur_used_reg;
        fresh_next     = fresh_reg;
        ctx_next       = ctx_reg;
        scan_addr_next = scan_addr_reg;
        chk_valid_next = chk_valid_reg;
        chk_addr_next  = chk_addr_reg;
        low_free_next  = low_free_reg;
        freed_next     = freed_reg;
        first_next     = first_reg;
        clr_cnt_next   = clr_cnt_reg;
        fmt_next       = fmt_reg;
        res_next       = res_reg;
        stat.idle      = 1'b0;
        stat.res_valid = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg;
        ram_wdata      = {1'b0, NO_NEXT};
        ram_re         = 1'b0;
        ram_raddr      = cur_reg;

        case (state_reg)
            S_CLEAR: begin
                // Sweep the table; entry 0 stays claimed as a terminated chain
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = {(clr_cnt_reg == '0), NO_NEXT};
                if (clr_cnt_reg == LAST_ENTRY) begin
                    low_free_next = CNT_W'(1);
                    clr_cnt_next  = '0;
                    if (fmt_reg) begin
                        fmt_next   = 1'b0;
                        res_next   = make_res(ST_OK, '0, '0);
                        state_next = S_DONE;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                end
            end

            S_IDLE: begin
                stat.idle = 1'b1;
                if (in_valid) begin
                    req_next = in_item;
                    case (req_type_t'(in_item.req_type))
                        REQ_FORMAT: begin
                            clr_cnt_next = '0;
                            fmt_next     = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        REQ_ALLOC: begin
                            ctx_next       = CTX_ALLOC;
                            scan_addr_next = low_free_reg;
                            chk_valid_next = 1'b0;
                            state_next     = S_SCAN;
                        end
                        default: begin
                            cur_next = in_item.start_index;
                            if ({1'b0, in_item.start_index} >= ENTRY_LIMIT) begin
                                res_next   = make_res(ST_RANGE, '0, '0);
                                state_next = S_DONE;
                            end else if (req_type_t'(in_item.req_type) == REQ_SEEK) begin
                                if (in_item.link_count == '0) begin
                                    res_next   = make_res(ST_OK, in_item.start_index, '0);
                                    state_next = S_DONE;
                                end else begin
                                    k_next     = in_item.link_count;
                                    ram_re     = 1'b1;
                                    ram_raddr  = in_item.start_index;
                                    state_next = S_SEEK_RD;
                                end
                            end else begin
                                freed_next = '0;
                                first_next = 1'b1;
                                ram_re     = 1'b1;
                                ram_raddr  = in_item.start_index;
                                state_next = S_FREE_RD;
                            end
                        end
                    endcase
                end
            end

            S_SEEK_RD: begin
                // Follow one link, stop at the chain end, or hand the chain end to the scan when extending
                cur_used_next = rd_used;
                if (nx_ok) begin
                    cur_next = nx[IDX_W-1:0];
                    k_next   = k_reg - IDX_W'(1);
                    if (k_reg == IDX_W'(1)) begin
                        res_next   = make_res(ST_OK, nx[IDX_W-1:0], '0);
                        state_next = S_DONE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = nx[IDX_W-1:0];
                    end
                end else if (!req_reg.extend) begin
                    res_next   = make_res(ST_END, cur_reg, '0);
                    state_next = S_DONE;
                end else begin
                    ctx_next       = CTX_SEEK;
                    scan_addr_next = low_free_reg;
                    chk_valid_next = 1'b0;
                    state_next     = S_SCAN;
                end
            end

            S_SEEK_ISSUE: begin
                ram_re     = 1'b1;
                ram_raddr  = cur_reg;
                state_next = S_SEEK_RD;
            end

            S_SCAN: begin
                // Issue one read a cycle, check the word read the cycle before, claim the first free one
                if (chk_valid_reg && !rd_used) begin
                    ram_we         = 1'b1;
                    ram_waddr      = chk_addr_reg;
                    ram_wdata      = {1'b1, NO_NEXT};
                    low_free_next  = {1'b0, chk_addr_reg} + CNT_W'(1);
                    fresh_next     = chk_addr_reg;
                    chk_valid_next = 1'b0;
                    if (ctx_reg == CTX_ALLOC) begin
                        res_next   = make_res(ST_OK, chk_addr_reg, '0);
                        state_next = S_DONE;
                    end else begin
                        state_next = S_LINK;
                    end
                end else if (scan_addr_reg >= ENTRY_LIMIT) begin
                    low_free_next  = ENTRY_LIMIT;
                    chk_valid_next = 1'b0;
                    if (ctx_reg == CTX_ALLOC) begin
                        res_next = make_res(ST_FULL, '0, '0);
                    end else begin
                        res_next = make_res(ST_FULL, cur_reg, '0);
                    end
                    state_next = S_DONE;
                end else begin
                    ram_re         = 1'b1;
                    ram_raddr      = scan_addr_reg[IDX_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_addr_next  = scan_addr_reg[IDX_W-1:0];
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                end
            end

            S_LINK: begin
                // Link the chain end to the fresh entry; keep its own in-use bit
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = {(cur_used_reg || (fresh_reg == cur_reg)), {1'b0, fresh_reg}};
                cur_next  = fresh_reg;
                k_next    = k_reg - IDX_W'(1);
                if (k_reg == IDX_W'(1)) begin
                    res_next   = make_res(ST_OK, fresh_reg, '0);
                    state_next = S_DONE;
                end else begin
                    state_next = S_SEEK_ISSUE;
                end
            end

            S_FREE_RD: begin
                // Release the entry read if it is the first or in use, then read the next one in the chain
                if (first_reg || rd_used) begin
                    ram_we     = 1'b1;
                    ram_waddr  = cur_reg;
                    ram_wdata  = {1'b0, NO_NEXT};
                    first_next = 1'b0;
                    freed_next = freed_reg + CNT_W'(1);
                    if ({1'b0, cur_reg} < low_free_reg) begin
                        low_free_next = {1'b0, cur_reg};
                    end
                    if (!nx_ok || (nx[IDX_W-1:0] == cur_reg)) begin
                        res_next   = make_res(ST_OK, '0, freed_reg + CNT_W'(1));
                        state_next = S_DONE;
                    end else begin
                        cur_next  = nx[IDX_W-1:0];
                        ram_re    = 1'b1;
                        ram_raddr = nx[IDX_W-1:0];
                    end
                end else begin
                    res_next   = make_res(ST_OK, '0, freed_reg);
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                stat.res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/fat_cluster_chain_manager_core_test.sv =====
// Self-checking testbench for the cluster chain manager: random and directed requests.
module fat_cluster_chain_manager_core_test;
    import fcm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 500000;
    localparam int TAIL_CYCLES = 64;
    localparam int HOLD_AT     = 350;
    localparam int HOLD_LEN    = 300;
    localparam int RAND_PER_PH = 145;

    typedef struct {
        in_item_t req;
        int       phase;
        bit       drain_first;
    } queued_req_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Predicted allocation table
    logic [LINK_W-1:0] fat_next [NUM_ENTRIES];
    bit                fat_used [NUM_ENTRIES];
    int unsigned       first_free;

    queued_req_t req_backlog [$];
    out_item_t   resp_due [$];

    int send_idle_pct [3] = '{11, 70, 0};
    int recv_idle_pct [3] = '{70, 11, 0};

    int gen_phase = 0;
    int cur_phase = 0;
    int n_items   = 0;
    int n_sent    = 0;
    int n_got     = 0;
    int n_bad     = 0;
    int quiet     = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit in_taken  = 1'b0;

    fat_cluster_chain_manager_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    // Clear every link and claim entry 0
    function automatic void fat_format();
        foreach (fat_next[i]) begin
            fat_next[i] = NO_NEXT;
            fat_used[i] = 1'b0;
        end
        fat_used[0] = 1'b1;
        first_free = 1;
    endfunction

    // Claim the lowest free entry; returns 0 when the table is full
    function automatic bit claim_entry(output int unsigned got);
        got = 0;
        for (int unsigned i = first_free; i < NUM_ENTRIES; i++) begin
            if (!fat_used[i]) begin
                fat_used[i] = 1'b1;
                fat_next[i] = NO_NEXT;
                first_free  = i + 1;
                got         = i;
                return 1'b1;
            end
        end
        first_free = NUM_ENTRIES;
        return 1'b0;
    endfunction

    // Apply one request to the predicted table and return its response
    function automatic out_item_t fat_response(in_item_t rq);
        out_item_t         res;
        logic [LINK_W-1:0] nx;
        int unsigned       cur;
        int unsigned       fresh;
        res = '0;
        case (req_type_t'(rq.req_type))
            REQ_FORMAT: fat_format();
            REQ_ALLOC: begin
                if (!claim_entry(fresh))
                    res.status = ST_FULL;
                else
                    res.entry_index = IDX_W'(fresh);
            end
            default: begin
                cur = rq.start_index;
                if (cur >= NUM_ENTRIES) begin
                    res.status = ST_RANGE;
                end else if (rq.req_type == REQ_SEEK) begin
                    // Follow links, growing the chain at its end when asked
                    for (int k = 0; k < int'(rq.link_count); k++) begin
                        nx = fat_next[cur];
                        if (nx == NO_NEXT || nx >= NUM_ENTRIES) begin
                            if (!rq.extend) begin
                                res.status = ST_END;
                                break;
                            end
                            if (!claim_entry(fresh)) begin
                                res.status = ST_FULL;
                                break;
                            end
                            fat_next[cur] = LINK_W'(fresh);
                            nx = LINK_W'(fresh);
                        end
                        cur = nx;
                    end
                    res.entry_index = IDX_W'(cur);
                end else begin
                    // Release the start entry, then walk only into entries in use
                    while (1) begin
                        nx = fat_next[cur];
                        fat_next[cur] = NO_NEXT;
                        fat_used[cur] = 1'b0;
                        if (cur < first_free)
                            first_free = cur;
                        res.freed_count = res.freed_count + 1'b1;
                        if (nx == NO_NEXT || nx >= NUM_ENTRIES || !fat_used[nx])
                            break;
                        cur = nx;
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic void add_req(req_type_t rt, logic [IDX_W-1:0] st,
                                    logic [IDX_W-1:0] lc, logic ex, bit drain);
        queued_req_t q;
        q.req.req_type    = rt;
        q.req.start_index = st;
        q.req.link_count  = lc;
        q.req.extend      = ex;
        q.phase           = gen_phase;
        q.drain_first     = drain;
        req_backlog.push_back(q);
        n_items++;
    endfunction

    // Predict on input accept, check on output accept, watch for a hang
    always @(posedge aclk) begin
        out_item_t want;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            resp_due.push_back(fat_response(s_item));
            n_sent <= n_sent + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            n_got++;
            if (resp_due.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("result %0d unexpected: status %0d entry %0d freed %0d",
                             n_got, m_item.status, m_item.entry_index, m_item.freed_count);
            end else begin
                want = resp_due.pop_front();
                if (m_item.status !== want.status || m_item.entry_index !== want.entry_index
                        || m_item.freed_count !== want.freed_count) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("result %0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 n_got, want.status, want.entry_index, want.freed_count,
                                 m_item.status, m_item.entry_index, m_item.freed_count);
                end
            end
        end
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Request driver: drop valid after accept, launch the next item or idle
    always @(negedge aclk) begin
        logic     go_valid;
        in_item_t go_item;
        go_valid = s_valid;
        go_item  = s_item;
        if (in_taken)
            go_valid = 1'b0;
        if (aresetn && !go_valid && req_backlog.size() != 0) begin
            if (req_backlog[0].drain_first && resp_due.size() != 0) begin
                go_valid = 1'b0;
            end else if ($urandom_range(0, 99) >= send_idle_pct[req_backlog[0].phase]) begin
                go_valid  = 1'b1;
                go_item   = req_backlog[0].req;
                cur_phase <= req_backlog[0].phase;
                void'(req_backlog.pop_front());
            end
        end
        s_valid <= go_valid;
        s_item  <= go_item;
    end

    // Response sink: random stalls plus one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_sent == HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct[cur_phase]);
        end
    end

    initial begin
        int unsigned      pick;
        req_type_t        rt;
        logic [IDX_W-1:0] st;
        logic [IDX_W-1:0] lc;
        logic             ex;

        fat_format();

        // Directed: chain build, seek ends, frees, full table, field extremes
        add_req(REQ_ALLOC,  14'd0,     14'd0,     1'b0, 1'b0);
        add_req(REQ_ALLOC,  14'd0,     14'd0,     1'b1, 1'b0);
        add_req(REQ_SEEK,   14'd1,     14'd3,     1'b1, 1'b0);
        add_req(REQ_SEEK,   14'd1,     14'd10,    1'b0, 1'b0);
        add_req(REQ_SEEK,   14'd1,     14'd0,     1'b0, 1'b0);
        add_req(REQ_SEEK,   14'd2,     14'd1,     1'b0, 1'b0);
        add_req(REQ_FREE,   14'd1,     14'd0,     1'b0, 1'b0);
        add_req(REQ_FREE,   14'd7,     14'd0,     1'b0, 1'b0);
        add_req(REQ_SEEK,   14'd9,     14'd2,     1'b1, 1'b0);
        add_req(REQ_FREE,   14'd0,     14'd0,     1'b0, 1'b0);
        add_req(REQ_ALLOC,  14'd0,     14'd0,     1'b0, 1'b0);
        add_req(REQ_SEEK,   14'h3FFF,  14'h3FFF,  1'b0, 1'b0);
        add_req(REQ_FORMAT, 14'h3FFF,  14'h3FFF,  1'b1, 1'b0);
        add_req(REQ_SEEK,   14'd0,     14'h3FFF,  1'b1, 1'b1);
        add_req(REQ_ALLOC,  14'h2AAA,  14'h1555,  1'b0, 1'b0);
        add_req(REQ_SEEK,   14'd5,     14'h3FFF,  1'b1, 1'b0);
        add_req(REQ_FREE,   14'd0,     14'd0,     1'b0, 1'b0);
        add_req(REQ_ALLOC,  14'd0,     14'd0,     1'b0, 1'b0);
        add_req(REQ_FREE,   14'h3FFF,  14'h3FFF,  1'b1, 1'b0);
        add_req(REQ_SEEK,   14'd0,     14'd1,     1'b0, 1'b0);
        add_req(REQ_FORMAT, 14'd0,     14'd0,     1'b0, 1'b1);

        // Random: mostly short chains in the low part of the table
        for (int ph = 0; ph < 3; ph++) begin
            gen_phase = ph;
            for (int n = 0; n < RAND_PER_PH; n++) begin
                pick = $urandom_range(0, 99);
                st   = IDX_W'($urandom);
                lc   = IDX_W'($urandom);
                ex   = 1'($urandom);
                if (pick < 1) begin
                    rt = REQ_FORMAT;
                end else if (pick < 31) begin
                    rt = REQ_ALLOC;
                end else if (pick < 66) begin
                    rt = REQ_SEEK;
                    if ($urandom_range(0, 99) < 85)
                        st = IDX_W'($urandom_range(0, 255));
                    if (ex)
                        lc = ($urandom_range(0, 49) == 0) ? IDX_W'($urandom_range(0, 400))
                                                          : IDX_W'($urandom_range(0, 12));
                    else if ($urandom_range(0, 99) < 70)
                        lc = IDX_W'($urandom_range(0, 16));
                end else begin
                    rt = REQ_FREE;
                    if ($urandom_range(0, 99) < 90)
                        st = IDX_W'($urandom_range(0, 255));
                end
                add_req(rt, st, lc, ex, n == 0);
            end
        end

        // Hold reset low, then release it
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every item and response, then let the block settle
        while (n_sent != n_items)
            @(negedge aclk);
        while (resp_due.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (n_bad == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
